[rtl/core/cjd_pkg.sv]
// ============================================================================
// Cluster job dispatcher package
// Shared widths, the job item type and a small helper function.
// ============================================================================
package cjd_pkg;

   // Fixed widths of the item fields.
   localparam int DurWidth   = 8;
   localparam int ProcsWidth = 7;
   localparam int CfgWidth   = 7;
   localparam int CountWidth = 7;
   localparam int QueueWidth = 5;
   localparam int TotalWidth = 32;
   localparam int LoadWidth  = 48;
   localparam int TickWidth  = 32;

   // Defaults for the top-level parameters.
   localparam int DefMaxProcs     = 64;
   localparam int DefQueueDepth   = 16;
   localparam int DefDurationBits = 8;

   // Reset value of the processor count register.
   localparam logic [CfgWidth-1:0] ProcCountReset = 7'd16;

   // Register indexes of the configuration port.
   localparam logic CSR_PROC_COUNT = 1'b0;

   // One job as carried from the front part to the engine.
   typedef struct packed {
      logic                  arrives;
      logic [DurWidth-1:0]   dur;
      logic [ProcsWidth-1:0] procs;
   } job_type;

   // Saturating increment of a 32-bit total.
   function automatic logic [TotalWidth-1:0] sat_inc(input logic [TotalWidth-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

[rtl/core/cjd_req_if.sv]
// ============================================================================
// Job request channel
// Valid/ready channel that carries one tick of the cluster per item.
// ============================================================================
interface cjd_req_if;
   import cjd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  job_arrives;
   logic [DurWidth-1:0]   job_duration;
   logic [ProcsWidth-1:0] job_procs;

   modport source (output valid, job_arrives, job_duration, job_procs, input ready);
   modport sink   (input valid, job_arrives, job_duration, job_procs, output ready);
endinterface

[rtl/core/cjd_rsp_if.sv]
// ============================================================================
// Job status channel
// Valid/ready channel that carries the cluster status after each tick.
// ============================================================================
interface cjd_rsp_if;
   import cjd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] busy_procs;
   logic [CountWidth-1:0] running_jobs;
   logic [QueueWidth-1:0] queued_jobs;
   logic [TotalWidth-1:0] arrived_total;
   logic [TotalWidth-1:0] completed_total;
   logic [TotalWidth-1:0] rejected_total;
   logic [TotalWidth-1:0] idle_ticks;
   logic [LoadWidth-1:0]  load_sum;

   modport source (output valid, busy_procs, running_jobs, queued_jobs, arrived_total,
                   completed_total, rejected_total, idle_ticks, load_sum, input ready);
   modport sink   (input valid, busy_procs, running_jobs, queued_jobs, arrived_total,
                   completed_total, rejected_total, idle_ticks, load_sum, output ready);
endinterface

[rtl/core/cjd_front.sv]
// ============================================================================
// Cluster job dispatcher front end
// Accepts tick items, masks the duration and holds them in a two-entry queue.
// ============================================================================
module cjd_front #(
   parameter int DURATION_BITS = cjd_pkg::DefDurationBits
) (
   input  logic             clock,
   input  logic             reset,
   cjd_req_if.sink          req,
   output logic             job_valid,
   output cjd_pkg::job_type job,
   input  logic             job_pop
);
   import cjd_pkg::*;

   localparam logic [DurWidth-1:0] DurMask = DurWidth'((64'd1 << DURATION_BITS) - 64'd1);

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   job_type    job_new;

   // Classify the incoming tick.
   always_comb begin
      job_new.arrives = req.job_arrives;
      job_new.dur     = req.job_duration & DurMask;
      job_new.procs   = req.job_procs;
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];

   // Queue pointers.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_new;
      end
   end
endmodule

[rtl/core/cjd_engine.sv]
// ============================================================================
// Cluster job dispatcher engine
// Runs one tick: accounting, queue admission, retire scan, dispatch, status.
// ============================================================================
module cjd_engine #(
   parameter int MAX_PROCS   = cjd_pkg::DefMaxProcs,
   parameter int QUEUE_DEPTH = cjd_pkg::DefQueueDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cjd_pkg::CfgWidth-1:0]   proc_count,
   input  logic                           job_valid,
   input  cjd_pkg::job_type               job,
   output logic                           job_pop,
   cjd_rsp_if.source                      rsp
);
   import cjd_pkg::*;

   localparam int CW   = $clog2(MAX_PROCS + 1);
   localparam int AW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int PW   = (CW > ProcsWidth) ? CW : ProcsWidth;
   localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW   = $clog2(QUEUE_DEPTH + 1);
   localparam int REW  = TickWidth + CW;
   localparam logic [CW-1:0]  MaxProcs   = CW'(MAX_PROCS);
   localparam logic [FW-1:0]  QueueDepth = FW'(QUEUE_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_SCAN  = 6'b000100,
      S_HEAD  = 6'b001000,
      S_DISP  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic                  started_ff, started_in;
   logic [TickWidth-1:0]  tick_ff, tick_in;
   logic [CW-1:0]         run_cnt_ff, run_cnt_in;
   logic [CW-1:0]         busy_ff, busy_in;
   logic [QAW-1:0]        head_ff, head_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [TotalWidth-1:0] arrive_ff, arrive_in;
   logic [TotalWidth-1:0] done_ff, done_in;
   logic [TotalWidth-1:0] reject_ff, reject_in;
   logic [TotalWidth-1:0] idle_ff, idle_in;
   logic [LoadWidth-1:0]  load_ff, load_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic [CW-1:0]         wr_idx_ff, wr_idx_in;
   logic                  rv_ff, rv_in;
   job_type               job_ff, job_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;

   logic [CountWidth-1:0] busy_out_ff;
   logic [CountWidth-1:0] runs_out_ff;
   logic [QueueWidth-1:0] fill_out_ff;
   logic [TotalWidth-1:0] arrive_out_ff;
   logic [TotalWidth-1:0] done_out_ff;
   logic [TotalWidth-1:0] reject_out_ff;
   logic [TotalWidth-1:0] idle_out_ff;
   logic [LoadWidth-1:0]  load_out_ff;

   // Run table: end tick and processors of each running job.
   logic [REW-1:0]        run_mem [MAX_PROCS];
   logic [REW-1:0]        run_rd_ff;
   logic                  run_we;
   logic [AW-1:0]         run_wa;
   logic [REW-1:0]        run_wd;

   // Wait queue of jobs not yet dispatched.
   job_type               fifo_mem [QUEUE_DEPTH];
   job_type               fifo_rd_ff;
   logic                  fifo_we;
   logic [QAW-1:0]        fifo_wa;

   logic [PW-1:0]         cap_wide;
   logic [CW-1:0]         cap;
   logic [CW-1:0]         free_procs;
   logic [LoadWidth:0]    load_sum;
   logic [QAW:0]          slot_sum;
   logic                  issue;
   logic [TickWidth-1:0]  ent_end;
   logic [CW-1:0]         ent_procs;

   // Usable capacity is the configured count limited to the table size.
   always_comb begin
      cap_wide   = (PW'(proc_count) > PW'(MAX_PROCS)) ? PW'(MAX_PROCS) : PW'(proc_count);
      cap        = cap_wide[CW-1:0];
      free_procs = cap - busy_ff;
      load_sum   = {1'b0, load_ff} + (LoadWidth + 1)'(busy_ff);
      slot_sum   = {1'b0, head_ff} + (QAW + 1)'(fill_ff);
      ent_end    = run_rd_ff[REW-1:CW];
      ent_procs  = run_rd_ff[CW-1:0];
      issue      = (rd_idx_ff < run_cnt_ff);
      rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);
   end

   // Tick sequencer.
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      tick_in      = tick_ff;
      run_cnt_in   = run_cnt_ff;
      busy_in      = busy_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      arrive_in    = arrive_ff;
      done_in      = done_ff;
      reject_in    = reject_ff;
      idle_in      = idle_ff;
      load_in      = load_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      rv_in        = rv_ff;
      job_in       = job_ff;
      job_pop      = 1'b0;
      run_we       = 1'b0;
      run_wa       = '0;
      run_wd       = '0;
      fifo_we      = 1'b0;
      fifo_wa      = (slot_sum >= (QAW + 1)'(QUEUE_DEPTH)) ?
                     QAW'(slot_sum - (QAW + 1)'(QUEUE_DEPTH)) : QAW'(slot_sum);
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = S_START;
            end
         end
         // Accounting of the previous tick and admission of the arrival.
         S_START: begin
            if (started_ff) begin
               if (run_cnt_ff == '0) begin
                  idle_in = sat_inc(idle_ff);
               end
               load_in = load_sum[LoadWidth] ? '1 : load_sum[LoadWidth-1:0];
            end
            started_in = 1'b1;
            if (job_ff.arrives) begin
               arrive_in = sat_inc(arrive_ff);
               if (fill_ff >= QueueDepth) begin
                  reject_in = sat_inc(reject_ff);
               end else begin
                  fifo_we = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            rd_idx_in = '0;
            wr_idx_in = '0;
            rv_in     = 1'b0;
            state_in  = S_SCAN;
         end
         // Retire scan: read one entry a cycle, keep the survivors in order.
         S_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            rv_in = issue;
            if (rv_ff) begin
               if (ent_end == tick_ff) begin
                  busy_in = (busy_ff >= ent_procs) ? busy_ff - ent_procs : '0;
                  done_in = sat_inc(done_ff);
               end else begin
                  run_we    = 1'b1;
                  run_wa    = wr_idx_ff[AW-1:0];
                  run_wd    = run_rd_ff;
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
            end
            if (!issue && !rv_ff) begin
               run_cnt_in = wr_idx_ff;
               state_in   = S_HEAD;
            end
         end
         // Wait for the queue head to be read and check for a head and free room.
         S_HEAD: begin
            if ((fill_ff != '0) && (busy_ff < cap) && (run_cnt_ff < MaxProcs)) begin
               state_in = S_DISP;
            end else begin
               state_in = S_OUT;
            end
         end
         // Dispatch the head if it fits.
         S_DISP: begin
            if (PW'(fifo_rd_ff.procs) <= PW'(free_procs)) begin
               run_we     = 1'b1;
               run_wa     = run_cnt_ff[AW-1:0];
               run_wd     = {tick_ff + TickWidth'(fifo_rd_ff.dur), CW'(fifo_rd_ff.procs)};
               run_cnt_in = run_cnt_ff + 1'b1;
               busy_in    = busy_ff + CW'(fifo_rd_ff.procs);
               head_in    = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               fill_in    = fill_ff - 1'b1;
               state_in   = S_HEAD;
            end else begin
               state_in = S_OUT;
            end
         end
         // Hand the status over once the output register is free.
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               tick_in      = tick_ff + 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         tick_ff      <= '0;
         run_cnt_ff   <= '0;
         busy_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         arrive_ff    <= '0;
         done_ff      <= '0;
         reject_ff    <= '0;
         idle_ff      <= '0;
         load_ff      <= '0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         tick_ff      <= tick_in;
         run_cnt_ff   <= run_cnt_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         arrive_ff    <= arrive_in;
         done_ff      <= done_in;
         reject_ff    <= reject_in;
         idle_ff      <= idle_in;
         load_ff      <= load_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Latched item and the status register.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (rsp_load) begin
         busy_out_ff   <= CountWidth'(busy_ff);
         runs_out_ff   <= CountWidth'(run_cnt_ff);
         fill_out_ff   <= QueueWidth'(fill_ff);
         arrive_out_ff <= arrive_ff;
         done_out_ff   <= done_ff;
         reject_out_ff <= reject_ff;
         idle_out_ff   <= idle_ff;
         load_out_ff   <= load_ff;
      end
   end

   // Run table memory.
   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_wa] <= run_wd;
      end
      run_rd_ff <= run_mem[rd_idx_ff[AW-1:0]];
   end

   // Wait queue memory.
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_wa] <= job_ff;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.busy_procs      = busy_out_ff;
   assign rsp.running_jobs    = runs_out_ff;
   assign rsp.queued_jobs     = fill_out_ff;
   assign rsp.arrived_total   = arrive_out_ff;
   assign rsp.completed_total = done_out_ff;
   assign rsp.rejected_total  = reject_out_ff;
   assign rsp.idle_ticks      = idle_out_ff;
   assign rsp.load_sum        = load_out_ff;
endmodule

[rtl/core/cluster_job_dispatcher.sv]
// ============================================================================
// Cluster job dispatcher
// FIFO job scheduler with processor admission, one status item per tick.
// ============================================================================
//  channel   direction  handshake        payload
//  req_chan  in         valid/ready      job_arrives, job_duration, job_procs
//  rsp_chan  out        valid/ready      busy/running/queued counts and totals
//  csr_*     in         APB write/read   proc_count at byte address 0
//
// An item passes the engine states in order: idle, start, a retire scan of the
// running jobs, a head check and a dispatch per job dispatched, a last head
// check with a failed dispatch when the head does not fit, and the output state.
// Reset is synchronous and clears all counters; memories hold no reset value.
// A two-entry input queue takes items while the engine works or while a
// status item waits in the output register.
module cluster_job_dispatcher #(
   parameter int MAX_PROCS     = cjd_pkg::DefMaxProcs,
   parameter int QUEUE_DEPTH   = cjd_pkg::DefQueueDepth,
   parameter int DURATION_BITS = cjd_pkg::DefDurationBits
) (
   input  logic        clock,
   input  logic        reset,
   cjd_req_if.sink     req_chan,
   cjd_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cjd_pkg::*;

   logic [CfgWidth-1:0] proc_count_ff, proc_count_in;
   logic                job_valid;
   job_type             job;
   logic                job_pop;
   logic                csr_write;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_PROC_COUNT);
   assign proc_count_in = csr_write ? csr_pwdata[CfgWidth-1:0] : proc_count_ff;
   assign csr_prdata    = (csr_paddr[2] == CSR_PROC_COUNT) ? 32'(proc_count_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= ProcCountReset;
      end else begin
         proc_count_ff <= proc_count_in;
      end
   end

   cjd_front #(
      .DURATION_BITS (DURATION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   cjd_engine #(
      .MAX_PROCS   (MAX_PROCS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .proc_count (proc_count_ff),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop),
      .rsp        (rsp_chan)
   );

   // Rejected jobs are a subset of arrived jobs.
   a_reject_le_arrive : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.rejected_total <= rsp_chan.arrived_total))
      else $error("rejected total exceeds arrived total");

   // Completed jobs were all admitted first.
   a_done_le_arrive : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.completed_total <= rsp_chan.arrived_total))
      else $error("completed total exceeds arrived total");

   // With no job running no processor is busy.
   a_idle_no_busy : assert property (@(posedge clock) disable iff (reset)
      (MAX_PROCS < 128) && rsp_chan.valid && (rsp_chan.running_jobs == '0)
      |-> (rsp_chan.busy_procs == '0))
      else $error("busy processors with no running job");
endmodule

[tb/cjd_tb_pkg.sv]
`timescale 1ns / 100ps
// ============================================================================
// Cluster dispatcher testbench package
// Expected-status type shared by the stimulus and the checker.
// ============================================================================
package cjd_tb_pkg;
   import cjd_pkg::*;

   // One cluster status item, as the block reports it after a tick.
   typedef struct packed {
      logic [CountWidth-1:0] busy;
      logic [CountWidth-1:0] running;
      logic [QueueWidth-1:0] queued;
      logic [TotalWidth-1:0] arrived;
      logic [TotalWidth-1:0] completed;
      logic [TotalWidth-1:0] rejected;
      logic [TotalWidth-1:0] idle;
      logic [LoadWidth-1:0]  load;
   } status_type;
endpackage

[tb/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// Cluster job dispatcher testbench
// Drives cluster ticks with random gaps, keeps a cycle-free model of the
// scheduler, and compares every status item with the predicted one.
// ============================================================================
module testbench;
   import cjd_pkg::*;
   import cjd_tb_pkg::*;

   localparam int MaxProcs   = 64;
   localparam int QueueDepth = 16;
   localparam int CycleLimit = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cjd_req_if req_chan ();
   cjd_rsp_if rsp_chan ();

   cluster_job_dispatcher dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Model state of the scheduler.
   logic [6:0]  proc_limit;
   logic [31:0] tick_now;
   bit          ticked;
   logic [31:0] run_start [MaxProcs];
   logic [7:0]  run_dur   [MaxProcs];
   logic [6:0]  run_need  [MaxProcs];
   int          n_running;
   int          n_busy;
   logic [7:0]  wait_dur  [$];
   logic [6:0]  wait_need [$];
   logic [31:0] n_arrived, n_done, n_rejected, n_idle;
   logic [47:0] load_total;

   status_type expected_status [$];
   int  mismatches = 0;
   int  statuses_seen = 0;
   int  cycles = 0;
   bit  rsp_random = 1'b1;

   initial forever #5 clock = ~clock;

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("%0t: timeout with %0d status items pending", $time,
                  expected_status.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == '1) ? v : v + 1;
   endfunction

   task automatic model_reset();
      proc_limit = ProcCountReset;
      tick_now = '0;
      ticked = 1'b0;
      n_running = 0;
      n_busy = 0;
      wait_dur.delete();
      wait_need.delete();
      n_arrived = '0; n_done = '0; n_rejected = '0; n_idle = '0;
      load_total = '0;
   endtask

   // Advances the scheduler model by one tick and queues the status.
   task automatic predict_tick(input logic arrives, input logic [7:0] dur,
                               input logic [6:0] need);
      int cap, keep;
      logic [48:0] sum;
      status_type s;
      cap = (proc_limit > MaxProcs) ? MaxProcs : proc_limit;
      if (ticked) begin
         if (n_running == 0) n_idle = bump(n_idle);
         sum = load_total + n_busy;
         load_total = (sum > 49'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
      end
      ticked = 1'b1;
      // Retire finished jobs, keeping the order of the rest.
      keep = 0;
      for (int r = 0; r < n_running; r++) begin
         if (32'(run_start[r] + run_dur[r]) == tick_now) begin
            n_busy = (n_busy >= run_need[r]) ? n_busy - run_need[r] : 0;
            n_done = bump(n_done);
         end else begin
            run_start[keep] = run_start[r];
            run_dur[keep] = run_dur[r];
            run_need[keep] = run_need[r];
            keep++;
         end
      end
      n_running = keep;
      if (arrives) begin
         n_arrived = bump(n_arrived);
         if (wait_dur.size() >= QueueDepth) n_rejected = bump(n_rejected);
         else begin
            wait_dur.push_back(dur);
            wait_need.push_back(need);
         end
      end
      // Dispatch the head while it fits.
      while (wait_dur.size() > 0 && n_busy < cap && n_running < MaxProcs) begin
         if (wait_need[0] > cap - n_busy) break;
         run_start[n_running] = tick_now;
         run_dur[n_running] = wait_dur.pop_front();
         run_need[n_running] = wait_need.pop_front();
         n_busy += run_need[n_running];
         n_running++;
      end
      tick_now++;
      s.busy = 7'(n_busy);
      s.running = 7'(n_running);
      s.queued = 5'(wait_dur.size());
      s.arrived = n_arrived;
      s.completed = n_done;
      s.rejected = n_rejected;
      s.idle = n_idle;
      s.load = load_total;
      expected_status.push_back(s);
   endtask

   // Sends one tick item after a random gap and predicts its status.
   // Valid stays high after the item until the next gap or a drain.
   task automatic send_tick(input logic arrives, input logic [7:0] dur,
                            input logic [6:0] need);
      int gap;
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.job_arrives <= arrives;
      req_chan.job_duration <= dur;
      req_chan.job_procs <= need;
      do @(posedge clock); while (!req_chan.ready);
      predict_tick(arrives, dur, need);
      @(negedge clock);
   endtask

   task automatic send_random_tick(input int p_arrive);
      logic [6:0] need;
      need = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(1, 12));
      send_tick($urandom_range(0, 99) < p_arrive, 8'($urandom_range(0, 255)) |
                (($urandom_range(0, 3) != 0) ? 8'h0 : 8'h0),
                need);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // APB write and read-back of the processor count, done only while the block is idle.
   task automatic write_proc_count(input logic [6:0] value);
      wait_drained();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 3'(CSR_PROC_COUNT) << 2;
      csr_pwdata <= {$urandom} & 32'hFFFF_FF80 | 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      proc_limit = value;
      // Read it back; psel stays high for the setup cycle of the read.
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[6:0] !== value) begin
         $display("%0t: proc_count readback expected %0d actual %0d", $time, value,
                  csr_prdata[6:0]);
         mismatches++;
      end
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   // Result side: random stalls, field by field comparison.
   initial begin
      status_type want, got;
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_random && $urandom_range(0, 2) == 0) begin
            stall = $urandom_range(0, 19);
            if (stall != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got = '{rsp_chan.busy_procs, rsp_chan.running_jobs, rsp_chan.queued_jobs,
                 rsp_chan.arrived_total, rsp_chan.completed_total,
                 rsp_chan.rejected_total, rsp_chan.idle_ticks, rsp_chan.load_sum};
         statuses_seen++;
         if (expected_status.size() == 0) begin
            $display("%0t: status item with none expected", $time);
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            if (got.busy !== want.busy)
               $display("%0t: busy_procs expected %0d actual %0d", $time, want.busy, got.busy);
            if (got.running !== want.running)
               $display("%0t: running_jobs expected %0d actual %0d", $time, want.running,
                        got.running);
            if (got.queued !== want.queued)
               $display("%0t: queued_jobs expected %0d actual %0d", $time, want.queued,
                        got.queued);
            if (got.arrived !== want.arrived)
               $display("%0t: arrived_total expected %0d actual %0d", $time, want.arrived,
                        got.arrived);
            if (got.completed !== want.completed)
               $display("%0t: completed_total expected %0d actual %0d", $time,
                        want.completed, got.completed);
            if (got.rejected !== want.rejected)
               $display("%0t: rejected_total expected %0d actual %0d", $time,
                        want.rejected, got.rejected);
            if (got.idle !== want.idle)
               $display("%0t: idle_ticks expected %0d actual %0d", $time, want.idle, got.idle);
            if (got.load !== want.load)
               $display("%0t: load_sum expected %0d actual %0d", $time, want.load, got.load);
            if (got !== want) mismatches++;
         end
         @(negedge clock);
      end
   end

   // First ticks, extremes of duration and need, a blocking oversized job.
   task automatic test_directed();
      send_tick(1'b0, 8'd0, 7'd0);
      send_tick(1'b0, 8'd0, 7'd0);
      send_tick(1'b1, 8'd1, 7'd1);
      send_tick(1'b1, 8'd255, 7'd16);
      send_tick(1'b1, 8'd2, 7'd0);
      send_tick(1'b1, 8'd3, 7'd127);
      send_tick(1'b1, 8'd1, 7'd1);
      send_tick(1'b1, 8'd0, 7'd64);
      send_tick(1'b0, 8'd170, 7'd85);
      send_tick(1'b1, 8'd85, 7'd42);
      repeat (5) send_tick(1'b0, 8'd255, 7'd127);
   endtask

   // Queue overflow: a stuck head with many arrivals behind it.
   task automatic test_overflow();
      write_proc_count(7'd4);
      send_tick(1'b1, 8'd20, 7'd4);
      send_tick(1'b1, 8'd5, 7'd40);
      repeat (22) send_tick(1'b1, 8'($urandom_range(1, 9)), 7'($urandom_range(1, 4)));
      repeat (25) send_tick(1'b0, 8'd0, 7'd0);
   endtask

   // Capacity settings: zero, lowered below busy, above the maximum.
   task automatic test_capacity();
      write_proc_count(7'd64);
      repeat (30) send_tick(1'b1, 8'($urandom_range(20, 60)), 7'($urandom_range(1, 6)));
      write_proc_count(7'd2);
      repeat (30) send_random_tick(60);
      write_proc_count(7'd0);
      repeat (20) send_random_tick(50);
      write_proc_count(7'd127);
      repeat (60) send_random_tick(90);
      write_proc_count(7'd100);
      // Many single-processor jobs so the run table can fill up.
      repeat (70) send_tick(1'b1, 8'($urandom_range(100, 250)), 7'd1);
   endtask

   // Long random phases over several capacities, each after a full drain, with one extra drain pause.
   task automatic test_random();
      logic [6:0] caps [5] = '{7'd16, 7'd1, 7'd8, 7'd33, 7'd64};
      foreach (caps[i]) begin
         write_proc_count(caps[i]);
         rsp_random = (i != 2);
         repeat (110) begin
            send_random_tick($urandom_range(10, 95));
         end
         if (i == 1) wait_drained();
      end
      rsp_random = 1'b1;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.job_arrives = 1'b0;
      req_chan.job_duration = '0;
      req_chan.job_procs = '0;
      model_reset();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_overflow();
      test_capacity();
      test_random();
      wait_drained();
      $display("Covered %0d status items over capacities 0 to 127, queue overflow,",
               statuses_seen);
      $display("zero-size and oversized jobs and a full run table.");
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/core/cjd_pkg.sv
rtl/core/cjd_req_if.sv
rtl/core/cjd_rsp_if.sv
rtl/core/cjd_front.sv
rtl/core/cjd_engine.sv
rtl/core/cluster_job_dispatcher.sv
tb/cjd_tb_pkg.sv
tb/testbench.sv
